@@ hdl/qnr_pkg.sv @@
package qnr_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned WORD_BITS_DEF = 32;

    localparam logic [2:0] REG_COEF4 = 3'd0;
    localparam logic [2:0] REG_COEF3 = 3'd1;
    localparam logic [2:0] REG_COEF2 = 3'd2;
    localparam logic [2:0] REG_COEF1 = 3'd3;
    localparam logic [2:0] REG_COEF0 = 3'd4;
    localparam logic [2:0] REG_TOL   = 3'd5;
    localparam logic [2:0] REG_LIMIT = 3'd6;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_ZERO_DER  = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DCOEF,
        OP_DER_MUL,
        OP_DER_ADD,
        OP_F_MUL,
        OP_F_ADD,
        OP_DIV_START,
        OP_STEP,
        OP_ERR_START,
        OP_ERR_DONE
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DCOEF,
        S_CHECK,
        S_DMUL,
        S_DADD,
        S_DTEST,
        S_FMUL,
        S_FADD,
        S_DIVS,
        S_DIVW,
        S_STEP,
        S_ERRS,
        S_ERRW,
        S_ERRD,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [2:0] k;
    } t_cmd;

    typedef struct packed {
        logic d_zero;
        logic x1_zero;
        logic conv;
        logic div_busy;
        logic limit_hit;
    } t_stat;

endpackage

@@ hdl/qnr_divider.sv @@
module qnr_divider import qnr_pkg::*; #(
    parameter int unsigned NUM_BITS = 112,
    parameter int unsigned DEN_BITS = 64,
    parameter int unsigned Q_BITS   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_busy,
    output logic [Q_BITS-1:0]   o_quot,
    output logic                o_ovf
);
    localparam int unsigned CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS:0]   r_rem;
    logic [Q_BITS-1:0]   r_quot;
    logic                r_ovf;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic [DEN_BITS:0]   n_shift;
    logic                n_ge;

    // Restoring division, one bit a cycle; the remainder stays below the divisor.
    always_comb begin
        n_shift = {r_rem[DEN_BITS-1:0], r_num[NUM_BITS-1]};
        n_ge    = n_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NUM_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_BITS-2:0], 1'b0};
            r_rem  <= n_ge ? n_shift - {1'b0, r_den} : n_shift;
            r_quot <= {r_quot[Q_BITS-2:0], n_ge};
            if (r_quot[Q_BITS-1]) begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;
endmodule

@@ hdl/qnr_datapath.sv @@
module qnr_datapath import qnr_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_guess,
    input  logic [31:0] i_coef4,
    input  logic [31:0] i_coef3,
    input  logic [31:0] i_coef2,
    input  logic [31:0] i_coef1,
    input  logic [31:0] i_coef0,
    input  logic [31:0] i_tol,
    input  logic [7:0]  i_limit,
    input  logic [7:0]  i_iters,
    output t_stat       o_stat,
    output logic [31:0] o_root,
    output logic [31:0] o_err
);
    localparam int unsigned W   = WORD_BITS;
    localparam int unsigned NB  = W + 7 + FRAC_BITS;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    typedef logic signed [W-1:0] t_w;

    function automatic t_w sat_ext(input logic [31:0] v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        if (e > 64'(WMAX)) return WMAX;
        if (e < 64'(WMIN)) return WMIN;
        return t_w'(e);
    endfunction

    function automatic t_w sadd(input t_w a, input t_w b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic t_w ssub(input t_w a, input t_w b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] mag(input t_w v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic t_w from_mag(input logic neg, input logic [W:0] m, input logic ovf);
        if (ovf || (!neg && m > {2'b0, {(W-1){1'b1}}}) ||
            (neg && m > {2'b01, {(W-1){1'b0}}})) return neg ? WMIN : WMAX;
        return neg ? t_w'(-m) : t_w'(m);
    endfunction

    t_w r_x, r_x1, r_acc, r_d4, r_d3, r_d2, r_d, r_c4, r_c3, r_c2, r_c1, r_c0;
    logic [31:0] r_err;
    logic [2*W-1:0] r_prod;
    logic           r_pneg;
    logic           r_dneg;
    logic           n_div_start;
    logic [NB-1:0]  n_num;
    logic [W-1:0]   n_den;
    logic           div_busy;
    logic [W-1:0]   div_q;
    logic           div_ovf;
    t_w             n_mulres;
    t_w             n_coef;
    logic [W:0]     n_pm;
    logic           n_povf;
    t_w             n_diff;

    qnr_divider #(.NUM_BITS(NB), .DEN_BITS(W), .Q_BITS(W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(n_div_start),
        .i_num  (n_num),
        .i_den  (n_den),
        .o_busy (div_busy),
        .o_quot (div_q),
        .o_ovf  (div_ovf)
    );

    // Q-format product from the registered full magnitude product.
    always_comb begin
        n_pm     = {1'b0, r_prod[W-1+FRAC_BITS:FRAC_BITS]};
        n_povf   = |r_prod[2*W-1:W+FRAC_BITS];
        n_mulres = from_mag(r_pneg, n_pm, n_povf);
        unique case (i_cmd.k)
            3'd0:    n_coef = (i_cmd.op == OP_DER_ADD) ? r_d3 : r_c3;
            3'd1:    n_coef = (i_cmd.op == OP_DER_ADD) ? r_d2 : r_c2;
            3'd2:    n_coef = r_c1;
            default: n_coef = r_c0;
        endcase
        n_diff = ssub(r_x1, r_x);
        n_div_start = (i_cmd.op == OP_DIV_START) || (i_cmd.op == OP_ERR_START);
        if (i_cmd.op == OP_DIV_START) begin
            n_num = NB'(mag(r_acc)) << FRAC_BITS;
            n_den = mag(r_d);
        end else begin
            n_num = NB'(NB'(mag(n_diff)) * NB'(100)) << FRAC_BITS;
            n_den = mag(r_x1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_x   <= sat_ext(i_guess);
                r_x1  <= sat_ext(i_guess);
                r_c4  <= sat_ext(i_coef4);
                r_c3  <= sat_ext(i_coef3);
                r_c2  <= sat_ext(i_coef2);
                r_c1  <= sat_ext(i_coef1);
                r_c0  <= sat_ext(i_coef0);
                r_err <= 32'(100) << FRAC_BITS;
            end
            OP_DCOEF: begin
                r_d4 <= sadd(sadd(sadd(r_c4, r_c4), r_c4), r_c4);
                r_d3 <= sadd(sadd(r_c3, r_c3), r_c3);
                r_d2 <= sadd(r_c2, r_c2);
                r_acc <= r_c4;
            end
            OP_DER_MUL, OP_F_MUL: begin
                r_prod <= (2*W)'(mag((i_cmd.k == 3'd0 && i_cmd.op == OP_DER_MUL) ? r_d4 :
                                     (i_cmd.k == 3'd0) ? r_c4 : r_acc)) * (2*W)'(mag(r_x));
                r_pneg <= ((i_cmd.k == 3'd0 && i_cmd.op == OP_DER_MUL) ? r_d4[W-1] :
                           (i_cmd.k == 3'd0) ? r_c4[W-1] : r_acc[W-1]) != r_x[W-1];
            end
            OP_DER_ADD: begin
                r_acc <= sadd(n_mulres, n_coef);
                if (i_cmd.k == 3'd2) begin
                    r_d <= sadd(n_mulres, n_coef);
                end
            end
            OP_F_ADD: begin
                r_acc <= sadd(n_mulres, n_coef);
            end
            OP_DIV_START: begin
                r_dneg <= r_acc[W-1] != r_d[W-1];
            end
            OP_STEP: begin
                r_x1 <= ssub(r_x, from_mag(r_dneg, {1'b0, div_q}, div_ovf));
            end
            OP_ERR_DONE: begin
                // A zero estimate leaves the error as it was.
                if (r_x1 != '0) begin
                    r_err <= (div_ovf || (W > 32 && |(div_q >> 32))) ? 32'hFFFF_FFFF :
                             32'(div_q);
                end
                r_x   <= r_x1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.d_zero    = (r_d == '0);
        o_stat.x1_zero   = (r_x1 == '0);
        o_stat.conv      = (r_err <= i_tol);
        o_stat.div_busy  = div_busy;
        o_stat.limit_hit = (i_iters >= i_limit);
        if (W > 32 && r_x1 > t_w'(64'sh7FFF_FFFF)) o_root = 32'h7FFF_FFFF;
        else if (W > 32 && r_x1 < t_w'(-64'sh8000_0000)) o_root = 32'h8000_0000;
        else o_root = 32'(r_x1);
        o_err = r_err;
    end
endmodule

@@ hdl/qnr_ctrl.sv @@
module qnr_ctrl import qnr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_out_taken,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_idle,
    output logic       o_done,
    output logic [7:0] o_iters,
    output logic [1:0] o_status
);
    t_state r_state, n_state;
    logic [2:0] r_k, n_k;
    logic [7:0] r_iters;
    logic [1:0] r_status;

    always_comb begin
        n_state = r_state;
        n_k = r_k;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_DCOEF;
            S_DCOEF: n_state = S_CHECK;
            S_CHECK: begin
                n_k = '0;
                n_state = i_stat.limit_hit ? S_DONE : S_DMUL;
            end
            S_DMUL:  n_state = S_DADD;
            S_DADD: begin
                if (r_k == 3'd2) begin
                    n_state = S_DTEST;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = S_DMUL;
                end
            end
            S_DTEST: begin
                n_k = '0;
                n_state = i_stat.d_zero ? S_DONE : S_FMUL;
            end
            S_FMUL:  n_state = S_FADD;
            S_FADD: begin
                if (r_k == 3'd3) begin
                    n_state = S_DIVS;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = S_FMUL;
                end
            end
            S_DIVS:  n_state = S_DIVW;
            S_DIVW:  if (!i_stat.div_busy) n_state = S_STEP;
            S_STEP:  n_state = S_ERRS;
            S_ERRS:  n_state = i_stat.x1_zero ? S_ERRD : S_ERRW;
            S_ERRW:  if (!i_stat.div_busy) n_state = S_ERRD;
            S_ERRD:  n_state = S_CHECK;
            S_DONE:  if (i_out_taken) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // Convergence is tested on the error written in S_ERRD.
        if (r_state == S_CHECK && r_iters != 8'd0 && i_stat.conv) n_state = S_DONE;
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        o_cmd.k  = r_k;
        unique case (r_state)
            S_IDLE:  if (i_start) o_cmd.op = OP_LOAD;
            S_DCOEF: o_cmd.op = OP_DCOEF;
            S_DMUL:  o_cmd.op = OP_DER_MUL;
            S_DADD:  o_cmd.op = OP_DER_ADD;
            S_FMUL:  o_cmd.op = OP_F_MUL;
            S_FADD:  o_cmd.op = OP_F_ADD;
            S_DIVS:  o_cmd.op = OP_DIV_START;
            S_STEP:  o_cmd.op = OP_STEP;
            S_ERRS:  o_cmd.op = i_stat.x1_zero ? OP_NONE : OP_ERR_START;
            // The datapath keeps the old error when the new estimate is zero.
            S_ERRD:  o_cmd.op = OP_ERR_DONE;
            default: o_cmd.op = OP_NONE;
        endcase
        o_idle   = (r_state == S_IDLE);
        o_done   = (r_state == S_DONE);
        o_iters  = r_iters;
        o_status = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_iters  <= '0;
            r_status <= ST_LIMIT;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (r_state == S_IDLE && i_start) begin
                r_iters  <= '0;
                r_status <= ST_LIMIT;
            end
            if (r_state == S_CHECK && !(r_iters != 8'd0 && i_stat.conv) &&
                !i_stat.limit_hit) r_iters <= r_iters + 1'b1;
            if (r_state == S_CHECK && r_iters != 8'd0 && i_stat.conv) r_status <= ST_CONVERGED;
            if (r_state == S_DTEST && i_stat.d_zero) r_status <= ST_ZERO_DER;
        end
    end
endmodule

@@ hdl/quartic_newton_root_solver_unit.sv @@
// Channel | Signals                               | Direction
// cfg     | i_cfg_valid/o_cfg_ready, index, data  | in
// guess   | i_in_valid/o_in_ready, initial_guess  | in
// result  | o_out_valid/i_out_ready, four fields  | out
// One guess is solved at a time. A Newton step evaluates the derivative and the polynomial,
// then runs two bit-serial divisions, one for the step and one for the error percent;
// a zero derivative ends the solve and a zero estimate skips the error division.
// Reset is synchronous; it restores the register defaults and idles the block.
// A result holds in the output until taken; the next guess is accepted after.
module quartic_newton_root_solver_unit import qnr_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_initial_guess,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_root,
    output logic [7:0]  o_iterations_used,
    output logic [1:0]  o_solve_status,
    output logic [31:0] o_error_percent
);
    logic [31:0] r_coef4, r_coef3, r_coef2, r_coef1, r_coef0, r_tol;
    logic [7:0]  r_limit;
    t_cmd  cmd;
    t_stat stat;
    logic  idle, done;
    logic  start;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = idle;
    assign start       = i_in_valid && idle;
    assign o_out_valid = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef4 <= 32'd65536;
            r_coef3 <= -32'sd563610;
            r_coef2 <= -32'sd2327183;
            r_coef1 <= 32'd30408704;
            r_coef0 <= -32'sd65435075;
            r_tol   <= 32'd65536;
            r_limit <= 8'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COEF4: r_coef4 <= i_cfg_data;
                REG_COEF3: r_coef3 <= i_cfg_data;
                REG_COEF2: r_coef2 <= i_cfg_data;
                REG_COEF1: r_coef1 <= i_cfg_data;
                REG_COEF0: r_coef0 <= i_cfg_data;
                REG_TOL:   r_tol   <= i_cfg_data;
                REG_LIMIT: r_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    qnr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_taken(i_out_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle),
        .o_done     (done),
        .o_iters    (o_iterations_used),
        .o_status   (o_solve_status)
    );

    qnr_datapath #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_guess(i_initial_guess),
        .i_coef4(r_coef4),
        .i_coef3(r_coef3),
        .i_coef2(r_coef2),
        .i_coef1(r_coef1),
        .i_coef0(r_coef0),
        .i_tol  (r_tol),
        .i_limit(r_limit),
        .i_iters(o_iterations_used),
        .o_stat (stat),
        .o_root (o_root),
        .o_err  (o_error_percent)
    );
endmodule

@@ hdl/qnr_checker.sv @@
module qnr_checker import qnr_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_solve_status,
    input logic [7:0] o_iterations_used
);
    // Input ready and output valid are never high together: one solve at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input ready while result pending");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_solve_status != 2'd3) else $error("bad status");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_iterations_used))
        else $error("result dropped");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_out_valid) else $error("result too soon");
endmodule

bind quartic_newton_root_solver_unit qnr_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_solve_status   (o_solve_status),
    .o_iterations_used(o_iterations_used)
);
